FILE: hw/rtl/tlbb_pkg.sv
// Shared types, register indexes and helpers for the text line bounding box core.
`default_nettype none

package tlbb_pkg;

    localparam int unsigned COORD_W = 12;
    localparam int unsigned SIZE_W  = 13;
    localparam int unsigned COUNT_LIMIT = 4096;

    localparam logic [SIZE_W-1:0] RESET_IMAGE_SIZE = 13'd1024;

    typedef enum logic [1:0] {
        CFG_IMAGE_WIDTH  = 2'd0,
        CFG_IMAGE_HEIGHT = 2'd1
    } cfg_index_t;

    // Extent of the current row, as seen with the pixel being accepted.
    typedef struct packed {
        logic               row_end;
        logic               has_ink;
        logic [COORD_W-1:0] first_ink;
        logic [COORD_W-1:0] last_ink;
    } row_info_t;

    // Clamps a size register to 1 .. lim; zero behaves as one.
    function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                     input logic [SIZE_W-1:0] lim);
        logic [SIZE_W-1:0] r;
        if (v == '0) begin
            r = 13'd1;
        end else if (v > lim) begin
            r = lim;
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/text_line_bounding_boxes_core.sv
// Top level: finds text line bounding boxes in a raster-order binary pixel stream.
//
// Pixels enter on the s_ channel, one item per pixel in raster order, with the
// ink bit in s_tdata[0]. Columns and rows are counted against image_width and
// image_height, each clamped to 1 .. min(MAX_*, 4096). When an empty row follows
// a text line, one item with that line's left, top, right and bottom bounds
// leaves on the m_ channel. A line still open at the last row is dropped.
// The block takes one pixel per clock while not stalled. A box appears on m_tvalid
// in the cycle after the last pixel of the empty row that closes the line; the path from
// input to result is one register deep, set by the output register.
// The output register is freed in the same cycle it is read, so the input
// stalls while a box waits and m_tready is low, and in the cycle of a write
// to image_width or image_height.
// The configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data) is
// always ready; index 0 writes image_width, index 1 image_height, and any such
// write restarts the frame. Write only while the block is idle.
// After reset both sizes are 1024, the frame starts at row 0 column 0 and no
// box is pending.
`default_nettype none

module text_line_bounding_boxes_core #(
    parameter int unsigned MAX_WIDTH  = 4096,
    parameter int unsigned MAX_HEIGHT = 4096
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // s_tdata: [0] ink, [7:1] zero
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,
    // m_tdata: [11:0] left_col, [23:12] top_row, [35:24] right_col, [47:36] bottom_row
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [47:0]      m_tdata,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [tlbb_pkg::SIZE_W-1:0] cfg_data
);
    import tlbb_pkg::*;

    localparam int unsigned W_LIM_I = (MAX_WIDTH < COUNT_LIMIT) ? MAX_WIDTH : COUNT_LIMIT;
    localparam int unsigned H_LIM_I = (MAX_HEIGHT < COUNT_LIMIT) ? MAX_HEIGHT : COUNT_LIMIT;
    localparam logic [SIZE_W-1:0] W_LIM = SIZE_W'(W_LIM_I);
    localparam logic [SIZE_W-1:0] H_LIM = SIZE_W'(H_LIM_I);

    logic [SIZE_W-1:0]  image_width_reg, image_width_next;
    logic [SIZE_W-1:0]  image_height_reg, image_height_next;
    logic [SIZE_W-1:0]  eff_width, eff_height, new_eff_width;

    logic [COORD_W-1:0] row_count_reg, row_count_next;
    logic [SIZE_W-1:0]  line_min_left_reg, line_min_left_next;
    logic [COORD_W-1:0] line_max_right_reg, line_max_right_next;
    logic               between_lines_reg, between_lines_next;
    logic [COORD_W-1:0] line_top_reg, line_top_next;

    logic               m_tvalid_reg, m_tvalid_next;
    logic [47:0]        m_tdata_reg, m_tdata_next;

    logic               cfg_write, cfg_restart, accept;
    logic               emit;
    logic [SIZE_W-1:0]  min_upd;
    logic [COORD_W-1:0] max_upd;
    logic [SIZE_W-1:0]  row_plus_one;
    row_info_t          row_info;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;
    assign cfg_restart = cfg_write && (cfg_index == CFG_IMAGE_WIDTH
                                       || cfg_index == CFG_IMAGE_HEIGHT);

    // A restarting register write holds off the pixel of the same cycle.
    assign s_tready = (!m_tvalid_reg || m_tready) && !cfg_restart;
    assign accept   = s_tvalid && s_tready;

    assign eff_width  = clamp_size(image_width_reg, W_LIM);
    assign eff_height = clamp_size(image_height_reg, H_LIM);

    always_comb begin
        image_width_next  = image_width_reg;
        image_height_next = image_height_reg;
        if (cfg_write) begin
            unique case (cfg_index)
                CFG_IMAGE_WIDTH:  image_width_next  = cfg_data;
                CFG_IMAGE_HEIGHT: image_height_next = cfg_data;
                default: ;
            endcase
        end
    end

    assign new_eff_width = clamp_size(image_width_next, W_LIM);

    tlbb_row_scan u_row_scan (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .restart   (cfg_restart),
        .step      (accept),
        .ink       (s_tdata[0]),
        .eff_width (eff_width),
        .info      (row_info)
    );

    assign row_plus_one = {1'b0, row_count_reg} + 13'd1;

    always_comb begin
        min_upd = line_min_left_reg;
        max_upd = line_max_right_reg;
        if (row_info.has_ink) begin
            if ({1'b0, row_info.first_ink} < line_min_left_reg) begin
                min_upd = {1'b0, row_info.first_ink};
            end
            if (row_info.last_ink > line_max_right_reg) begin
                max_upd = row_info.last_ink;
            end
        end
    end

    always_comb begin
        row_count_next      = row_count_reg;
        line_min_left_next  = line_min_left_reg;
        line_max_right_next = line_max_right_reg;
        between_lines_next  = between_lines_reg;
        line_top_next       = line_top_reg;
        emit                = 1'b0;
        m_tvalid_next       = m_tvalid_reg && !m_tready;
        m_tdata_next        = m_tdata_reg;

        if (cfg_restart) begin
            row_count_next      = '0;
            line_min_left_next  = new_eff_width;
            line_max_right_next = '0;
            between_lines_next  = 1'b0;
            line_top_next       = '0;
        end else if (accept && row_info.row_end) begin
            line_min_left_next  = min_upd;
            line_max_right_next = max_upd;
            if (row_info.has_ink && between_lines_reg) begin
                line_top_next      = row_count_reg;
                between_lines_next = 1'b0;
            end else if (!row_info.has_ink && !between_lines_reg) begin
                between_lines_next = 1'b1;
                // An empty first row only marks the gap; later empty rows close a line.
                if (row_count_reg != '0) begin
                    emit                = 1'b1;
                    line_min_left_next  = eff_width;
                    line_max_right_next = '0;
                end
            end

            if (row_plus_one < eff_height) begin
                row_count_next = row_plus_one[COORD_W-1:0];
            end else begin
                row_count_next      = '0;
                line_min_left_next  = eff_width;
                line_max_right_next = '0;
                between_lines_next  = 1'b0;
                line_top_next       = '0;
            end
        end

        if (emit) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = {row_count_reg - 12'd1, max_upd, line_top_reg,
                             min_upd[COORD_W-1:0]};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            image_width_reg    <= RESET_IMAGE_SIZE;
            image_height_reg   <= RESET_IMAGE_SIZE;
            row_count_reg      <= '0;
            line_min_left_reg  <= clamp_size(RESET_IMAGE_SIZE, W_LIM);
            line_max_right_reg <= '0;
            between_lines_reg  <= 1'b0;
            line_top_reg       <= '0;
            m_tvalid_reg       <= 1'b0;
        end else begin
            image_width_reg    <= image_width_next;
            image_height_reg   <= image_height_next;
            row_count_reg      <= row_count_next;
            line_min_left_reg  <= line_min_left_next;
            line_max_right_reg <= line_max_right_next;
            between_lines_reg  <= between_lines_next;
            line_top_reg       <= line_top_next;
            m_tvalid_reg       <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // The input only stalls while a finished box is waiting or a size is written.
    a_stall_only_on_pending : assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (m_tvalid || cfg_restart))
        else $error("input stalled without a pending box");

    a_row_in_frame : assert property (@(posedge aclk) disable iff (!aresetn)
        row_count_reg < eff_height[COORD_W-1:0] || eff_height == 13'd4096)
        else $error("row counter beyond frame height");

    a_min_left_bound : assert property (@(posedge aclk) disable iff (!aresetn)
        line_min_left_reg <= eff_width)
        else $error("line left bound beyond image width");

    // A new box is only loaded at the end of a row.
    a_emit_at_row_end : assert property (@(posedge aclk) disable iff (!aresetn)
        emit |-> (accept && row_info.row_end && !row_info.has_ink))
        else $error("box emitted outside an empty row end");

endmodule

`default_nettype wire

FILE: hw/rtl/tlbb_row_scan.sv
// Column counter and first/last inked column tracking within one row.
`default_nettype none

module tlbb_row_scan (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        restart,
    input  wire logic                        step,
    input  wire logic                        ink,
    input  wire logic [tlbb_pkg::SIZE_W-1:0] eff_width,
    output tlbb_pkg::row_info_t              info
);
    import tlbb_pkg::*;

    logic [COORD_W-1:0] col_count_reg, col_count_next;
    logic               has_ink_reg, has_ink_next;
    logic [COORD_W-1:0] first_ink_reg, first_ink_next;
    logic [COORD_W-1:0] last_ink_reg, last_ink_next;
    logic [SIZE_W-1:0]  col_plus_one;

    assign col_plus_one = {1'b0, col_count_reg} + 13'd1;

    // The row extent including the pixel being accepted now.
    always_comb begin
        info.row_end   = col_plus_one >= eff_width;
        info.has_ink   = has_ink_reg | ink;
        info.first_ink = (ink && !has_ink_reg) ? col_count_reg : first_ink_reg;
        info.last_ink  = ink ? col_count_reg : last_ink_reg;
    end

    always_comb begin
        col_count_next = col_count_reg;
        has_ink_next   = has_ink_reg;
        first_ink_next = first_ink_reg;
        last_ink_next  = last_ink_reg;
        if (restart) begin
            col_count_next = '0;
            has_ink_next   = 1'b0;
            first_ink_next = '0;
            last_ink_next  = '0;
        end else if (step) begin
            if (info.row_end) begin
                col_count_next = '0;
                has_ink_next   = 1'b0;
                first_ink_next = '0;
                last_ink_next  = '0;
            end else begin
                col_count_next = col_plus_one[COORD_W-1:0];
                has_ink_next   = info.has_ink;
                first_ink_next = info.first_ink;
                last_ink_next  = info.last_ink;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_count_reg <= '0;
            has_ink_reg   <= 1'b0;
            first_ink_reg <= '0;
            last_ink_reg  <= '0;
        end else begin
            col_count_reg <= col_count_next;
            has_ink_reg   <= has_ink_next;
            first_ink_reg <= first_ink_next;
            last_ink_reg  <= last_ink_next;
        end
    end

endmodule

`default_nettype wire
